/* rtl/bxds_pkg.sv */
// Shared types and constants for the box average downscaler.
// Used by the controller, the datapath and the top level.
package bxds_pkg;

  localparam int MaxWidth = 2048;
  localparam int MaxBlock = 64;
  localparam int QuotW    = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] CfgBlockSize   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd2;

  typedef struct packed {
    logic accept;
    logic acc;
    logic div_step;
  } dp_cmd_t;

  typedef struct packed {
    logic complete;
  } dp_status_t;

endpackage

/* rtl/bxds_ctrl.sv */
// Sequencer for the downscaler: pixel accept, accumulate, divide, output.
// Depends on bxds_pkg.
module bxds_ctrl
  import bxds_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StAcc  = 4'b0010,
    StDiv  = 4'b0100,
    StOut  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [$clog2(QuotW)-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StAcc;
      StAcc: begin
        cnt_d   = '0;
        state_d = status_i.complete ? StDiv : StIdle;
      end
      StDiv: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ($clog2(QuotW))'(QuotW - 1)) state_d = StOut;
      end
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o     = (state_q == StIdle);
  assign out_valid_o    = (state_q == StOut);
  assign cmd_o.accept   = in_ready_o && in_valid_i;
  assign cmd_o.acc      = (state_q == StAcc);
  assign cmd_o.div_step = (state_q == StDiv);

endmodule

/* rtl/bxds_dp.sv */
// Datapath: config registers, raster counters, column sum store, divider.
// Depends on bxds_pkg; driven by bxds_ctrl.
module bxds_dp
  import bxds_pkg::*;
#(
  parameter int MAX_WIDTH = MaxWidth,
  parameter int MAX_BLOCK = MaxBlock
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [23:0]         pix_i,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o,
  output logic [23:0]         mean_o,
  output logic                last_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int SZW = $clog2(MAX_WIDTH + 1);
  localparam int BW  = $clog2(MAX_BLOCK + 1);
  localparam int PW  = SZW + BW + 1;
  localparam int SW  = 2 * BW + 8;
  localparam int DW  = 2 * BW;
  localparam int HW  = DW + QuotW - 1;

  logic [6:0]          bs_cfg_q;
  logic [CfgDataW-1:0] fw_q, fh_q;
  logic [BW-1:0]       bs;
  logic [SZW-1:0]      w, h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_cfg_q <= 7'd1;
      fw_q     <= 12'd2048;
      fh_q     <= 12'd2048;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBlockSize:   bs_cfg_q <= cfg_data_i[6:0];
        CfgFrameWidth:  fw_q     <= cfg_data_i;
        CfgFrameHeight: fh_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bs_cfg_q == '0) bs = BW'(1);
    else if (int'(bs_cfg_q) > MAX_BLOCK) bs = BW'(MAX_BLOCK);
    else bs = BW'(bs_cfg_q);
    if (fw_q == '0) w = SZW'(1);
    else if (int'(fw_q) > MAX_WIDTH) w = SZW'(MAX_WIDTH);
    else w = SZW'(fw_q);
    if (fh_q == '0) h = SZW'(1);
    else if (int'(fh_q) > MAX_WIDTH) h = SZW'(MAX_WIDTH);
    else h = SZW'(fh_q);
  end

  // raster position
  logic [CW-1:0] col_q, row_q, bcol_q;
  logic [BW-1:0] cib_q, rib_q;
  logic [PW-1:0] cstart_q, rstart_q;
  logic          restart;

  assign restart = cfg_we_i && (cfg_idx_i == CfgBlockSize ||
                   cfg_idx_i == CfgFrameWidth || cfg_idx_i == CfgFrameHeight);

  logic [PW-1:0] bs_x, w_x, h_x;
  logic          in_whole, is_last, is_first, is_complete;
  assign bs_x = PW'(bs);
  assign w_x  = PW'(w);
  assign h_x  = PW'(h);
  assign in_whole = (cstart_q + bs_x <= w_x) && (rstart_q + bs_x <= h_x);
  assign is_last  = (cstart_q + bs_x + bs_x > w_x) && (rstart_q + bs_x + bs_x > h_x);
  assign is_first = (cib_q == '0) && (rib_q == '0);
  assign is_complete = (cib_q == bs - 1'b1) && (rib_q == bs - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0; row_q <= '0; bcol_q <= '0;
      cib_q <= '0; rib_q <= '0; cstart_q <= '0; rstart_q <= '0;
    end else if (restart) begin
      col_q <= '0; row_q <= '0; bcol_q <= '0;
      cib_q <= '0; rib_q <= '0; cstart_q <= '0; rstart_q <= '0;
    end else if (cmd_i.accept) begin
      if (SZW'(col_q) + 1'b1 >= w) begin
        col_q <= '0; cib_q <= '0; bcol_q <= '0; cstart_q <= '0;
        if (SZW'(row_q) + 1'b1 >= h) begin
          row_q <= '0; rib_q <= '0; rstart_q <= '0;
        end else begin
          row_q <= row_q + 1'b1;
          if (rib_q + 1'b1 >= bs) begin
            rib_q    <= '0;
            rstart_q <= rstart_q + bs_x;
          end else begin
            rib_q <= rib_q + 1'b1;
          end
        end
      end else begin
        col_q <= col_q + 1'b1;
        if (cib_q + 1'b1 >= bs) begin
          cib_q    <= '0;
          bcol_q   <= bcol_q + 1'b1;
          cstart_q <= cstart_q + bs_x;
        end else begin
          cib_q <= cib_q + 1'b1;
        end
      end
    end
  end

  // column sum store
  logic [3*SW-1:0] mem [MAX_WIDTH];
  logic [3*SW-1:0] rd_q, sum;
  logic [CW-1:0]   addr_q;
  logic [23:0]     pix_q;
  logic            first_q, wr_q, complete_q, last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_q    <= mem[bcol_q];
      addr_q  <= bcol_q;
      pix_q   <= pix_i;
      first_q <= is_first;
      last_q  <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q       <= 1'b0;
      complete_q <= 1'b0;
    end else if (cmd_i.accept) begin
      wr_q       <= in_whole;
      complete_q <= in_whole && is_complete;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c*SW +: SW] = (first_q ? '0 : rd_q[c*SW +: SW]) + SW'(pix_q[c*8 +: 8]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc && wr_q) mem[addr_q] <= sum;
  end

  assign status_o.complete = complete_q;

  // restoring divider, one quotient bit per step
  logic [DW-1:0]    div_q;
  logic [HW-1:0]    dsh_q;
  logic [3*SW-1:0]  rem_q;
  logic [23:0]      quo_q;
  logic             olast_q;

  always_ff @(posedge clk_i) begin
    div_q <= DW'(bs) * DW'(bs);
    if (cmd_i.acc) begin
      rem_q   <= sum;
      dsh_q   <= HW'(div_q) << (QuotW - 1);
      quo_q   <= '0;
      olast_q <= last_q;
    end else if (cmd_i.div_step) begin
      dsh_q <= dsh_q >> 1;
      for (int c = 0; c < 3; c++) begin
        if (rem_q[c*SW +: SW] >= SW'(dsh_q)) begin
          rem_q[c*SW +: SW] <= rem_q[c*SW +: SW] - SW'(dsh_q);
          quo_q[c*8 +: 8]   <= {quo_q[c*8 +: 7], 1'b1};
        end else begin
          quo_q[c*8 +: 8]   <= {quo_q[c*8 +: 7], 1'b0};
        end
      end
    end
  end

  assign mean_o = quo_q;
  assign last_o = olast_q;

endmodule

/* rtl/box_average_downscale.sv */
// Top level of the box average downscaler.
// Depends on bxds_pkg, bxds_ctrl and bxds_dp.
// Accepts RGB pixels in raster order and emits the truncated mean of each
// whole block_size square, in raster order of the reduced frame, with
// frame_end flagged on the last one. Each pixel goes through a column sum
// read, then an add and write back; a pixel that completes a block adds a
// run of the shared one-bit-per-cycle divider plus the output transfer,
// during which no pixel is taken. The column sum store needs no clearing.
// Writing block size, width or height restarts the frame at its first pixel.
module box_average_downscale
  import bxds_pkg::*;
#(
  parameter int MAX_WIDTH = MaxWidth,
  parameter int MAX_BLOCK = MaxBlock
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,  // red, green, blue
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,  // red_mean, green_mean, blue_mean
  output logic                m_axis_tuser   // frame_end
);

  dp_cmd_t    cmd;
  dp_status_t status;

  bxds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bxds_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (s_axis_tdata),
    .cmd_i      (cmd),
    .status_o   (status),
    .mean_o     (m_axis_tdata),
    .last_o     (m_axis_tuser)
  );

endmodule

/* rtl/bxds_checker.sv */
// Port-level checks for box_average_downscale, attached by bind.
// Depends on bxds_pkg.
module bxds_checker
  import bxds_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while result pending");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid && !s_axis_tready)
    else $error("pixel not accumulated before next step");

endmodule

bind box_average_downscale bxds_checker u_bxds_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
